>>> sv/aes_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and GF(2^8) helpers for the AES-128 round pipeline.
// Depends on nothing; every file but the checker refers to it by scoped names.

package aes_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int BLOCK_W = 128;
   localparam int HALF_W = 64;

   // Configuration register indexes.
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW = 2'd1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [7:0] byte_type;
   typedef logic [31:0] word_type;

   // What one cell hands to the next: the cipher state and the round key it was
   // last combined with.
   typedef struct packed {
      block_type state;
      block_type rkey;
   } stage_type;

   localparam byte_type SBOX [0:255] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam byte_type RCON [0:NUM_ROUNDS-1] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam byte_type GF_POLY = 8'h1b;

   // Multiply by x modulo x^8 + x^4 + x^3 + x + 1.
   function automatic byte_type xtime(input byte_type v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   // Byte i of a block in FIPS order sits in the most significant bits first.
   function automatic byte_type get_byte(input block_type b, input int i);
      get_byte = b[BLOCK_W-1-8*i -: 8];
   endfunction

endpackage

>>> sv/aes_round_cell.sv
`timescale 1ns / 1ps
// One cell of the round chain: expands the next round key and applies one
// AES round to the state handed over by the previous cell. Uses aes_pkg.

module aes_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  aes_pkg::stage_type  in_stage,
   input  aes_pkg::byte_type   rcon,
   input  logic                last_round,
   output logic                out_valid,
   output aes_pkg::stage_type  out_stage
);

   logic               valid_ff;
   aes_pkg::stage_type stage_ff;
   aes_pkg::stage_type stage_in;

   aes_pkg::word_type  w0, w1, w2, w3, tw;
   aes_pkg::word_type  n0, n1, n2, n3;
   aes_pkg::block_type next_key;
   aes_pkg::byte_type  sb [16];
   aes_pkg::byte_type  mx [16];
   aes_pkg::block_type round_out;

   // Key expansion for this round.
   always_comb begin
      w0 = in_stage.rkey[127:96];
      w1 = in_stage.rkey[95:64];
      w2 = in_stage.rkey[63:32];
      w3 = in_stage.rkey[31:0];
      tw = {aes_pkg::SBOX[w3[23:16]] ^ rcon, aes_pkg::SBOX[w3[15:8]],
            aes_pkg::SBOX[w3[7:0]], aes_pkg::SBOX[w3[31:24]]};
      n0 = w0 ^ tw;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      next_key = {n0, n1, n2, n3};
   end

   // SubBytes and ShiftRows; state byte at row r, column c is byte 4c + r.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sb[4*c+r] = aes_pkg::SBOX[aes_pkg::get_byte(in_stage.state,
                                                        4*((c+r)%4)+r)];
         end
      end
   end

   // MixColumns, skipped in the final round.
   always_comb begin
      aes_pkg::byte_type a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = sb[4*c];
         a1 = sb[4*c+1];
         a2 = sb[4*c+2];
         a3 = sb[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         mx[4*c]   = last_round ? a0 : (a0 ^ all ^ aes_pkg::xtime(a0 ^ a1));
         mx[4*c+1] = last_round ? a1 : (a1 ^ all ^ aes_pkg::xtime(a1 ^ a2));
         mx[4*c+2] = last_round ? a2 : (a2 ^ all ^ aes_pkg::xtime(a2 ^ a3));
         mx[4*c+3] = last_round ? a3 : (a3 ^ all ^ aes_pkg::xtime(a3 ^ a0));
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         round_out[aes_pkg::BLOCK_W-1-8*i -: 8] = mx[i];
      end
      stage_in.state = round_out ^ next_key;
      stage_in.rkey = next_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

>>> sv/aes128_block_encrypt_top.sv
`timescale 1ns / 1ps
// AES-128 encryption: a loading stage and a chain of ten round cells.
// The result strobe is the valid register of the last cell, behind the loading register; one
// block can be accepted every cycle while busy is low, set by the one-round-per-cell
// chain, and the receiver cannot stall the chain. Synchronous active-high reset clears all
// valid flags and both key registers; busy is high during reset and for one cycle after it.
// Depends on aes_pkg and aes_round_cell.

module aes128_block_encrypt_top (
   input  logic        clock,
   input  logic        reset,
   // Block input
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   // Result output; the receiver cannot stall it.
   output logic        rsp_valid,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   // Key register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_high_ff, key_high_in;
   logic [63:0] key_low_ff, key_low_in;
   logic        busy_ff;
   logic        load_valid_ff;
   aes_pkg::stage_type load_stage_ff, load_stage_in;

   logic               cell_valid [0:aes_pkg::NUM_ROUNDS];
   aes_pkg::stage_type cell_stage [0:aes_pkg::NUM_ROUNDS];

   // The key registers take a write on every transfer; writes to unknown
   // indexes are dropped. Each block carries its own copy of the round key
   // down the chain, so a new key affects only blocks accepted afterwards.
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in = key_low_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            aes_pkg::CSR_KEY_HIGH: key_high_in = csr_data;
            aes_pkg::CSR_KEY_LOW:  key_low_in = csr_data;
            default: ;
         endcase
      end
   end

   // The loading stage applies the initial AddRoundKey.
   always_comb begin
      load_stage_in.rkey = {key_high_ff, key_low_ff};
      load_stage_in.state = {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         busy_ff <= 1'b1;
         load_valid_ff <= 1'b0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff <= key_low_in;
         busy_ff <= 1'b0;
         load_valid_ff <= start && !busy;
      end
      load_stage_ff <= load_stage_in;
   end

   assign busy = busy_ff || reset;
   assign csr_ready = !reset;

   assign cell_valid[0] = load_valid_ff;
   assign cell_stage[0] = load_stage_ff;

   // Cell i performs round i with its own round constant.
   for (genvar i = 1; i <= aes_pkg::NUM_ROUNDS; i++) begin : g_round
      aes_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (cell_valid[i-1]),
         .in_stage   (cell_stage[i-1]),
         .rcon       (aes_pkg::RCON[i-1]),
         .last_round (i == aes_pkg::NUM_ROUNDS),
         .out_valid  (cell_valid[i]),
         .out_stage  (cell_stage[i])
      );
   end

   // The last cell's register drives the result ports for one cycle per block.
   assign rsp_valid = cell_valid[aes_pkg::NUM_ROUNDS];
   assign rsp_cipher_high =
      cell_stage[aes_pkg::NUM_ROUNDS].state[aes_pkg::BLOCK_W-1 -: aes_pkg::HALF_W];
   assign rsp_cipher_low = cell_stage[aes_pkg::NUM_ROUNDS].state[aes_pkg::HALF_W-1:0];

endmodule

>>> sv/aes_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the AES-128 pipeline timing, bound to the top level.
// Depends on aes128_block_encrypt_top.

module aes_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Every accepted block produces its result through the loading register and the round cells.
   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid)
      else $error("accepted block did not produce a result after 11 cycles");

   // No result appears without a matching accepted block.
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 11))
      else $error("result strobe without a matching accepted block");

   // Reset flushes the chain.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind aes128_block_encrypt_top aes_checker u_aes_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

>>> verif/aes128_block_encrypt_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for aes128_block_encrypt_top: sends plaintext blocks, writes the key
// registers, predicts each ciphertext with a behavioral AES-128 model and compares every result.
// Depends on aes_pkg and the RTL of aes128_block_encrypt_top.

module aes128_block_encrypt_top_tb;

   // Register indexes with no register behind them; writes there must be ignored.
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [7:0] REDUCTION_POLY = 8'h1b;
   localparam int IDLE_PERCENT = 16;
   localparam int RESULT_LATENCY = 11;
   localparam int RANDOM_PHASE_BLOCKS = 1150;
   localparam int BACK_TO_BACK_BLOCKS = 300;

   typedef struct {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } cipher_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        rsp_valid;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   // The key as the block should hold it, updated on every accepted transfer to a key register.
   logic [63:0] key_high_model = '0;
   logic [63:0] key_low_model = '0;

   // Ciphertexts of accepted blocks that have not come back yet, oldest first.
   cipher_type pending_cipher_q[$];
   int mismatch_count = 0;

   // When clear, the sender offers a new block on every cycle.
   bit gaps_enabled = 1'b1;

   aes128_block_encrypt_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_plain_high (req_plain_high),
      .req_plain_low  (req_plain_low),
      .rsp_valid      (rsp_valid),
      .rsp_cipher_high(rsp_cipher_high),
      .rsp_cipher_low (rsp_cipher_low),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The run must end well before this; a hang anywhere lands here.
   initial begin : watchdog
      #2ms;
      $display("aes128_block_encrypt_top regression: fail");
      $finish;
   end

   // Multiplication by x in GF(2^8).
   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? REDUCTION_POLY : 8'h00);
   endfunction

   // Full AES-128 encryption of one block. Byte 0 of both key and block sits in the
   // top eight bits; the state byte of row r and column c is st[4c + r].
   function automatic logic [127:0] encrypt_block(input logic [127:0] cipher_key,
                                                  input logic [127:0] plain);
      logic [7:0] round_key [0:175];
      logic [7:0] st [0:15];
      logic [7:0] shifted [0:15];
      logic [7:0] w [0:3];
      logic [7:0] rot, a0, a1, a2, a3, sum;
      logic [127:0] cipher;
      int i, j, rnd, c, r;
      for (i = 0; i < 16; i++) begin
         round_key[i] = cipher_key[127-8*i -: 8];
         st[i] = plain[127-8*i -: 8] ^ round_key[i];
      end
      // Key expansion: every fourth word is rotated, substituted and given a round constant.
      for (i = 4; i < 44; i++) begin
         for (j = 0; j < 4; j++) w[j] = round_key[4*(i-1)+j];
         if (i % 4 == 0) begin
            rot = w[0];
            w[0] = aes_pkg::SBOX[w[1]] ^ aes_pkg::RCON[i/4-1];
            w[1] = aes_pkg::SBOX[w[2]];
            w[2] = aes_pkg::SBOX[w[3]];
            w[3] = aes_pkg::SBOX[rot];
         end
         for (j = 0; j < 4; j++) round_key[4*i+j] = round_key[4*(i-4)+j] ^ w[j];
      end
      for (rnd = 1; rnd <= aes_pkg::NUM_ROUNDS; rnd++) begin
         // SubBytes and ShiftRows together: row r moves left by r columns.
         for (c = 0; c < 4; c++)
            for (r = 0; r < 4; r++)
               shifted[4*c+r] = aes_pkg::SBOX[st[4*((c+r)%4)+r]];
         // The last round has no MixColumns.
         if (rnd < aes_pkg::NUM_ROUNDS) begin
            for (c = 0; c < 4; c++) begin
               a0 = shifted[4*c];
               a1 = shifted[4*c+1];
               a2 = shifted[4*c+2];
               a3 = shifted[4*c+3];
               sum = a0 ^ a1 ^ a2 ^ a3;
               shifted[4*c]   = a0 ^ sum ^ gf_double(a0 ^ a1);
               shifted[4*c+1] = a1 ^ sum ^ gf_double(a1 ^ a2);
               shifted[4*c+2] = a2 ^ sum ^ gf_double(a2 ^ a3);
               shifted[4*c+3] = a3 ^ sum ^ gf_double(a3 ^ a0);
            end
         end
         for (i = 0; i < 16; i++) st[i] = shifted[i] ^ round_key[16*rnd+i];
      end
      for (i = 0; i < 16; i++) cipher[127-8*i -: 8] = st[i];
      return cipher;
   endfunction

   // Offers one block, after a random number of idle cycles, and records its ciphertext
   // once the transfer has happened. Start stays high on return so that the next block
   // can follow on the very next cycle.
   task automatic send_block(input logic [63:0] plain_high, input logic [63:0] plain_low);
      logic [127:0] cipher;
      cipher_type expected;
      while (gaps_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         // Junk on the data ports while start is low must not be taken.
         start <= 1'b0;
         req_plain_high <= {$urandom(), $urandom()};
         req_plain_low <= {$urandom(), $urandom()};
         @(posedge clock);
      end
      start <= 1'b1;
      req_plain_high <= plain_high;
      req_plain_low <= plain_low;
      @(posedge clock);
      while (busy) @(posedge clock);
      cipher = encrypt_block({key_high_model, key_low_model}, {plain_high, plain_low});
      expected.cipher_high = cipher[127:64];
      expected.cipher_low = cipher[63:0];
      pending_cipher_q.push_back(expected);
   endtask

   // Stops sending and waits until every ciphertext in flight has been checked. With one
   // result per block, an empty queue means the round pipeline is empty too.
   task automatic drain;
      if (start) begin
         start <= 1'b0;
         @(posedge clock);
      end
      while (pending_cipher_q.size() != 0) @(posedge clock);
   endtask

   // One register transfer; valid then drops for a cycle so back-to-back calls stay clean.
   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == aes_pkg::CSR_KEY_HIGH) key_high_model = value;
      else if (index == aes_pkg::CSR_KEY_LOW) key_low_model = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] key_high, input logic [63:0] key_low);
      write_register(aes_pkg::CSR_KEY_HIGH, key_high);
      write_register(aes_pkg::CSR_KEY_LOW, key_low);
   endtask

   // Both key registers come out of reset as zero.
   task automatic test_reset_key;
      send_block('0, '0);
      send_block('1, '1);
   endtask

   // The worked examples of the standard, which also confirm the prediction itself.
   task automatic test_standard_vectors;
      logic [127:0] cipher;
      cipher = encrypt_block(128'h000102030405060708090a0b0c0d0e0f,
                             128'h00112233445566778899aabbccddeeff);
      if (cipher !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
         mismatch_count++;
         $display("%0t: predicted cipher wrong, expected %h, actual %h", $time,
                  128'h69c4e0d86a7b0430d8cdb78070b4c55a, cipher);
      end
      drain();
      write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      write_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
   endtask

   // All-ones and alternating keys against the extreme plaintexts and single set bits.
   task automatic test_key_extremes;
      drain();
      write_key('1, '1);
      send_block('0, '0);
      send_block('1, '1);
      send_block({16{4'h5}}, {16{4'ha}});
      send_block({16{4'ha}}, {16{4'h5}});
      drain();
      write_key({16{4'h5}}, {16{4'ha}});
      send_block(64'h8000_0000_0000_0000, 64'h1);
      send_block(64'h1, 64'h8000_0000_0000_0000);
   endtask

   // Writes to the two unused indexes leave the key as it was.
   task automatic test_unused_index;
      drain();
      write_register(CSR_SPARE_2, {$urandom(), $urandom()});
      write_register(CSR_SPARE_3, {$urandom(), $urandom()});
      send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
   endtask

   // A new half of the key takes effect on the very next block.
   task automatic test_key_change_between_blocks;
      drain();
      write_register(aes_pkg::CSR_KEY_LOW, {$urandom(), $urandom()});
      send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
      drain();
      write_register(aes_pkg::CSR_KEY_HIGH, {$urandom(), $urandom()});
      send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
   endtask

   // Phases of random blocks, each under a key set while the pipeline is empty. The first
   // two phases use the all-zero and all-ones keys; later ones change one or both halves.
   task automatic test_random_keys;
      int sent, phase, count, k;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_PHASE_BLOCKS) begin
         drain();
         if (phase == 0) write_key('0, '0);
         else if (phase == 1) write_key('1, '1);
         else begin
            case ($urandom_range(3))
               0: write_register(aes_pkg::CSR_KEY_HIGH, {$urandom(), $urandom()});
               1: write_register(aes_pkg::CSR_KEY_LOW, {$urandom(), $urandom()});
               2: begin
                  write_register(CSR_SPARE_2 | 2'($urandom_range(1)), {$urandom(), $urandom()});
                  write_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
               end
               default: write_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
            endcase
         end
         count = $urandom_range(60, 130);
         for (k = 0; k < count; k++) begin
            send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
            // Now and then the sender holds off until everything in flight is back.
            if ($urandom_range(99) == 0) drain();
         end
         sent += count;
         phase++;
      end
   endtask

   // A long stretch with a new block offered on every cycle.
   task automatic test_back_to_back;
      int k;
      drain();
      write_key({$urandom(), $urandom()}, {$urandom(), $urandom()});
      gaps_enabled = 1'b0;
      for (k = 0; k < BACK_TO_BACK_BLOCKS; k++)
         send_block({$urandom(), $urandom()}, {$urandom(), $urandom()});
      gaps_enabled = 1'b1;
   endtask

   // Every result strobe is matched against the oldest outstanding ciphertext. The strobe
   // is compared against zero so that an unknown strobe is caught as well.
   always @(posedge clock) begin : check_results
      cipher_type expected;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_cipher_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with no block outstanding, expected none, actual %h %h",
                     $time, rsp_cipher_high, rsp_cipher_low);
         end else begin
            expected = pending_cipher_q.pop_front();
            if (rsp_cipher_high !== expected.cipher_high) begin
               mismatch_count++;
               $display("%0t: cipher_high mismatch, expected %h, actual %h", $time,
                        expected.cipher_high, rsp_cipher_high);
            end
            if (rsp_cipher_low !== expected.cipher_low) begin
               mismatch_count++;
               $display("%0t: cipher_low mismatch, expected %h, actual %h", $time,
                        expected.cipher_low, rsp_cipher_low);
            end
         end
      end
   end

   // Reset is held at the start and never again; the tests then run in turn. After the
   // last transfer the pipeline is drained and the bench keeps running so that any stray
   // extra result would still be seen by the checker.
   initial begin : run_tests
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_standard_vectors();
      test_key_extremes();
      test_unused_index();
      test_key_change_between_blocks();
      test_random_keys();
      test_back_to_back();
      drain();
      repeat (2 * RESULT_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && pending_cipher_q.size() == 0) begin
         $display("aes128_block_encrypt_top regression: pass");
      end else begin
         $display("aes128_block_encrypt_top regression: fail");
      end
      $finish;
   end

endmodule

>>> aes128_block_encrypt_top.f
sv/aes_pkg.sv
sv/aes_round_cell.sv
sv/aes128_block_encrypt_top.sv
sv/aes_checker.sv
verif/aes128_block_encrypt_top_tb.sv
